>>> rtl/rapq_pkg.sv
// rapq_pkg: shared types, constants and helpers for the range-add / point-query tree
// used by rapq_engine and range_add_point_query_tree_unit
// no dependencies
package rapq_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int NODE_COUNT    = 4096;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int POS_W         = 11;
    localparam int WORD_W        = 32;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int ADDR_W        = 3;
    localparam int IN_W          = 56;

    localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(MAX_POSITIONS);
    localparam logic [ADDR_W-1:0] REG_SIZE_ADDR = ADDR_W'(0);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NODE_W-1:0] node_t;

    // one node visit: heap index and the span it covers
    typedef struct packed {
        node_t node;
        pos_t  lo;
        pos_t  hi;
    } frame_t;

    typedef struct packed {
        logic    start;
        opcode_t op;
        pos_t    range_low;
        pos_t    range_high;
        word_t   delta;
        pos_t    size;
    } rapq_req_t;

    typedef struct packed {
        logic  idle;
        logic  res_load;
        word_t res_value;
    } rapq_rsp_t;

    // size 0 acts as 1, anything above the capacity is clamped
    function automatic pos_t eff_size(input pos_t size);
        pos_t r;
        if (size == '0)
            r = POS_W'(1);
        else if (size > POS_W'(MAX_POSITIONS))
            r = POS_W'(MAX_POSITIONS);
        else
            r = size;
        return r;
    endfunction

endpackage

>>> rtl/rapq_engine.sv
// rapq_engine: node store and walk sequencer with one shared 32-bit adder
// depends on rapq_pkg
module rapq_engine
    import rapq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rapq_req_t req,
    input  logic      out_free,
    output rapq_rsp_t rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_VISIT = 7'b0000100,
        S_NODE  = 7'b0001000,
        S_LEFT  = 7'b0010000,
        S_RIGHT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    node_t               clr_cnt_reg, clr_cnt_next;
    frame_t              stack_reg [STACK_DEPTH];
    logic                stack_wr;
    frame_t              stack_wdata;
    frame_t              cur_reg, cur_next;
    pos_t                a_reg, a_next;
    pos_t                b_reg, b_next;
    word_t               d_reg, d_next;
    word_t               acc_reg, acc_next;
    word_t               p_reg, p_next;
    logic                is_add_reg, is_add_next;
    logic                res_load;

    word_t               mem [NODE_COUNT];
    word_t               rdata_reg;
    logic                mem_re;
    node_t               mem_raddr;
    logic                mem_we;
    node_t               mem_waddr;
    word_t               mem_wdata;

    pos_t                mid;
    frame_t              left_frame;
    frame_t              right_frame;
    logic                disjoint;
    logic                covered;
    word_t               add_b;
    word_t               sum;

    // span split and range tests for the current node
    assign mid = POS_W'(({1'b0, cur_reg.lo} + {1'b0, cur_reg.hi}) >> 1);
    assign left_frame  = '{node: {cur_reg.node[NODE_W-2:0], 1'b0}, lo: cur_reg.lo, hi: mid};
    assign right_frame = '{node: {cur_reg.node[NODE_W-2:0], 1'b1}, lo: POS_W'(mid + 1'b1),
                           hi: cur_reg.hi};
    assign disjoint = (b_reg < cur_reg.lo) || (cur_reg.hi < a_reg);
    assign covered  = (a_reg <= cur_reg.lo) && (cur_reg.hi <= b_reg);

    // the one shared adder
    always_comb
    begin
        case (state_reg)
            S_NODE:  add_b = is_add_reg ? d_reg : acc_reg;
            S_LEFT,
            S_RIGHT: add_b = p_reg;
            default: add_b = d_reg;
        endcase
    end
    assign sum = rdata_reg + add_b;

    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        d_next       = d_reg;
        acc_next     = acc_reg;
        p_next       = p_reg;
        is_add_next  = is_add_reg;
        stack_wr     = 1'b0;
        stack_wdata  = right_frame;
        mem_re       = 1'b0;
        mem_raddr    = cur_reg.node;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg.node;
        mem_wdata    = sum;
        res_load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_ADD,
                        OP_QUERY:
                        begin
                            a_next      = req.range_low;
                            b_next      = (req.op == OP_QUERY) ? req.range_low : req.range_high;
                            d_next      = req.delta;
                            acc_next    = '0;
                            is_add_next = (req.op == OP_ADD);
                            sp_next     = '0;
                            cur_next    = '{node: NODE_W'(1), lo: POS_W'(1),
                                            hi: eff_size(req.size)};
                            state_next  = S_VISIT;
                        end
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    state_next = S_IDLE;
            end
            S_VISIT:
            begin
                if (disjoint)
                begin
                    if (sp_reg == '0)
                        state_next = S_DONE;
                    else
                    begin
                        cur_next = stack_reg[sp_reg - 1'b1];
                        sp_next  = sp_reg - 1'b1;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_reg.node;
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                if (covered)
                begin
                    if (is_add_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_reg.node;
                        mem_wdata = sum;
                    end
                    else
                        acc_next = sum;
                    if (sp_reg == '0)
                        state_next = S_DONE;
                    else
                    begin
                        cur_next   = stack_reg[sp_reg - 1'b1];
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_VISIT;
                    end
                end
                else
                begin
                    // split: move the pending value down before descending
                    p_next    = rdata_reg;
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg.node;
                    mem_wdata = '0;
                    if (rdata_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = left_frame.node;
                        state_next = S_LEFT;
                    end
                    else
                    begin
                        stack_wr   = 1'b1;
                        sp_next    = sp_reg + 1'b1;
                        cur_next   = left_frame;
                        state_next = S_VISIT;
                    end
                end
            end
            S_LEFT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = left_frame.node;
                mem_wdata  = sum;
                mem_re     = 1'b1;
                mem_raddr  = right_frame.node;
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = right_frame.node;
                mem_wdata  = sum;
                stack_wr   = 1'b1;
                sp_next    = sp_reg + 1'b1;
                cur_next   = left_frame;
                state_next = S_VISIT;
            end
            S_DONE:
            begin
                if (is_add_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.idle      = (state_reg == S_IDLE);
    assign rsp.res_load  = res_load;
    assign rsp.res_value = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            sp_reg      <= '0;
            clr_cnt_reg <= '0;
            is_add_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            clr_cnt_reg <= clr_cnt_next;
            is_add_reg  <= is_add_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
        if (stack_wr)
            stack_reg[sp_reg] <= stack_wdata;
    end

    // node store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

>>> rtl/range_add_point_query_tree_unit.sv
// range_add_point_query_tree_unit: top level, stream ports, register port, result register
// depends on rapq_pkg and rapq_engine
//
// channel   direction  handshake                          payload
// s_*       in         s_tvalid / s_tready                s_tdata (opcode, range_low,
//                                                         range_high, delta)
// m_*       out        m_tvalid / m_tready                m_tdata (point_value)
// apb       in/out     psel, penable, pwrite, pready      paddr, pwdata, prdata (size_in_use)
//
// in the walk sequencer a node off the range is dropped in the visit state, a node that is split
// or covered is read in the visit state and handled in the node state, and a push of a pending
// value to the children adds the left and right states; the walk is limited by the single port
// pair of the node store
// clear sweeps the store one node a cycle; after reset the same sweep runs and s_tready stays
// low until it ends (register writes are taken throughout)
// a query result sits in the output register; the next item is taken while it waits, and a
// following query holds in its done state until that result is taken
module range_add_point_query_tree_unit
    import rapq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // opcode[1:0], range_low[12:2], range_high[23:13],
                                         // delta[55:24]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,   // point_value[31:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    pos_t      size_reg;
    logic      m_tvalid_reg;
    word_t     m_tdata_reg;
    rapq_req_t req;
    rapq_rsp_t rsp;
    logic      s_accept;
    logic      out_free;
    logic      size_sel;

    assign pready   = 1'b1;
    assign size_sel = (paddr[ADDR_W-1:2] == REG_SIZE_ADDR[ADDR_W-1:2]);
    assign prdata   = size_sel ? {{(32-POS_W){1'b0}}, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RESET;
        else if (psel && penable && pwrite && pready && size_sel)
            size_reg <= pwdata[POS_W-1:0];
    end

    assign s_tready = rsp.idle;
    assign s_accept = s_tvalid && s_tready;

    assign req.start      = s_accept;
    assign req.op         = opcode_t'(s_tdata[1:0]);
    assign req.range_low  = s_tdata[12:2];
    assign req.range_high = s_tdata[23:13];
    assign req.delta      = s_tdata[55:24];
    assign req.size       = size_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    rapq_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .rsp      (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (rsp.res_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp.res_load)
            m_tdata_reg <= rsp.res_value;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.res_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded while output register full");

    // only a query transaction can lead to a result
    a_no_result_for_add: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tdata[1:0] != OP_QUERY)) |=> !rsp.res_load)
        else $error("result produced for a non-query transaction");

    // a started walk or clear keeps the input side closed
    a_busy_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && ((s_tdata[1:0] == OP_QUERY) || (s_tdata[1:0] == OP_ADD)
            || (s_tdata[1:0] == OP_CLEAR))) |=> !s_tready)
        else $error("input accepted while engine busy");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for range_add_point_query_tree_unit
// streams range adds, point queries and clears through the unit and predicts point values
// depends on rapq_pkg and range_add_point_query_tree_unit
module tb;
    import rapq_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DIR_N = 25;
    localparam int PHASE_N = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int CLEAR_SETTLE = 4200;
    localparam int TAIL_CYCLES = 200;
    localparam int LONG_HOLD = 400;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic [1:0] op;
        pos_t       lo;
        pos_t       hi;
        word_t      delta;
        logic       known;
        word_t      value;
    } tree_row_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    word_t node_sum [NODE_COUNT];
    pos_t  tree_size;
    word_t point_values_due [$];
    int    errors = 0;
    bit    quiet = 1'b0;
    bit    hold_req = 1'b0;

    // directed rows: known values follow from the adds above them at size 1024
    tree_row_t dir_rows [DIR_N] = '{
        '{OP_QUERY,  11'd1,    11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY,  11'd1024, 11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_ADD,    11'd1,    11'd1024, 32'h0000_0005, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd1,    11'd0,    32'h0000_0000, 1'b1, 32'h0000_0005},
        '{OP_QUERY,  11'd1024, 11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0000_0005},
        '{OP_ADD,    11'd1,    11'd1,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd1,    11'd0,    32'h0000_0000, 1'b1, 32'h8000_0004},
        '{OP_ADD,    11'd1024, 11'd1024, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd1024, 11'd0,    32'h0000_0000, 1'b1, 32'h8000_0005},
        '{OP_ADD,    11'd300,  11'd200,  32'h0000_004D, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd250,  11'd0,    32'h0000_0000, 1'b1, 32'h0000_0005},
        '{OP_ADD,    11'd0,    11'd0,    32'h0000_0009, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd0,    11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_ADD,    11'd1025, 11'd2047, 32'h0000_0003, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd2047, 11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY,  11'd1025, 11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_ADD,    11'd0,    11'd2047, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd512,  11'd0,    32'h0000_0000, 1'b1, 32'h0000_0004},
        '{OP_ADD,    11'd3,    11'd1000, 32'h1234_5678, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd999,  11'd0,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{OP_UNUSED, 11'd5,    11'd6,    32'h0000_0001, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd5,    11'd0,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{OP_CLEAR,  11'd0,    11'd0,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{OP_QUERY,  11'd700,  11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY,  11'd1,    11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    pos_t phase_size [PHASE_N] = '{11'd37, 11'd1, 11'd0, 11'd2, 11'd2047, 11'd3,
                                   11'd1000, 11'd1024};

    range_add_point_query_tree_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // opcode, range_low, range_high, delta
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // point_value
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("tb: mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic word_t node_rd(input int unsigned k);
        return (k < NODE_COUNT) ? node_sum[k] : '0;
    endfunction

    function automatic void node_wr(input int unsigned k, input word_t val);
        if (k < NODE_COUNT)
            node_sum[k] = val;
    endfunction

    function automatic void tree_clear();
        for (int i = 0; i < NODE_COUNT; i++)
            node_sum[i] = '0;
    endfunction

    // iterative descent; left subtree is finished before the right one is split
    function automatic word_t tree_walk(input int unsigned a, input int unsigned b,
                                        input bit add_mode, input word_t d);
        int unsigned stk_k [64];
        int unsigned stk_lo [64];
        int unsigned stk_hi [64];
        int sp;
        int unsigned k, lo, hi, mid, span;
        word_t acc, p;
        acc = '0;
        span = (tree_size == '0) ? 1 :
               (tree_size > MAX_POSITIONS) ? MAX_POSITIONS : tree_size;
        stk_k[0] = 1;
        stk_lo[0] = 1;
        stk_hi[0] = span;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            k = stk_k[sp];
            lo = stk_lo[sp];
            hi = stk_hi[sp];
            if (b < lo || hi < a)
                continue;
            if (a <= lo && hi <= b)
            begin
                if (add_mode)
                    node_wr(k, node_rd(k) + d);
                else
                    acc += node_rd(k);
                continue;
            end
            if (k >= NODE_COUNT)
                continue;
            mid = (lo + hi) >> 1;
            p = node_rd(k);
            if (p != '0)
            begin
                node_wr(2 * k, node_rd(2 * k) + p);
                node_wr(2 * k + 1, node_rd(2 * k + 1) + p);
                node_wr(k, '0);
            end
            stk_k[sp] = 2 * k + 1;
            stk_lo[sp] = mid + 1;
            stk_hi[sp] = hi;
            stk_k[sp + 1] = 2 * k;
            stk_lo[sp + 1] = lo;
            stk_hi[sp + 1] = mid;
            sp += 2;
        end
        return acc;
    endfunction

    function automatic word_t tree_apply(input logic [1:0] op, input pos_t lo, input pos_t hi,
                                         input word_t d);
        word_t r;
        r = '0;
        case (op)
            OP_ADD:   void'(tree_walk(lo, hi, 1'b1, d));
            OP_QUERY: r = tree_walk(lo, lo, 1'b0, '0);
            OP_CLEAR: tree_clear();
            default:  ;
        endcase
        return r;
    endfunction

    task automatic send_op(input logic [1:0] op, input pos_t lo, input pos_t hi,
                           input word_t d, input logic known, input word_t value);
        int unsigned gap;
        word_t got;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {d, hi, lo, op};
        do
            @(posedge clk);
        while (!s_tready);
        got = tree_apply(op, lo, hi, d);
        if (op == OP_QUERY)
            point_values_due = {point_values_due, (known ? value : got)};
    endtask

    task automatic wait_results_drained();
        while (point_values_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= wr;
        paddr <= REG_SIZE_ADDR;
        pwdata <= data;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr)
            tree_size = pos_t'(data);
        else if (prdata !== {21'b0, tree_size})
            report_mismatch("size_in_use readback", prdata, {21'b0, tree_size});
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial
    begin : result_side
        int unsigned hold;
        word_t want;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (point_values_due.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, '0);
                else
                begin
                    want = point_values_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("point_value", m_tdata, want);
                end
                hold = quiet ? 0 : $urandom_range(0, 10);
                if (hold_req)
                begin
                    hold = LONG_HOLD;
                    hold_req = 1'b0;
                end
                if (hold != 0)
                    m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
                m_tready <= 1'b0;
            end
            else if (hold != 0)
            begin
                hold--;
                if (hold == 0)
                    m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [1:0] op;
        pos_t lo, hi;
        int unsigned span, r;
        tree_clear();
        tree_size = SIZE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_op(dir_rows[i].op, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].delta,
                    dir_rows[i].known, dir_rows[i].value);

        for (int ph = 0; ph < PHASE_N; ph++)
        begin
            s_tvalid <= 1'b0;
            wait_results_drained();
            // a clear leaves no result to wait for, so let its sweep finish
            repeat (CLEAR_SETTLE) @(posedge clk);
            apb_access(1'b1, {21'b0, phase_size[ph]});
            apb_access(1'b0, '0);
            if (ph == 0)
                hold_req = 1'b1;
            span = (tree_size == '0) ? 1 :
                   (tree_size > MAX_POSITIONS) ? MAX_POSITIONS : tree_size;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                quiet = (n % 50) < 10;
                r = $urandom_range(0, 99);
                op = (r < 45) ? OP_ADD : (r < 93) ? OP_QUERY : (r < 95) ? OP_CLEAR : OP_UNUSED;
                if ($urandom_range(0, 9) == 0)
                begin
                    lo = pos_t'($urandom_range(0, 2047));
                    hi = pos_t'($urandom_range(0, 2047));
                end
                else
                begin
                    lo = pos_t'($urandom_range(1, span));
                    hi = pos_t'($urandom_range(lo, span));
                end
                if (op != OP_ADD)
                    hi = pos_t'($urandom_range(0, 2047));
                send_op(op, lo, hi, $urandom, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        quiet = 1'b0;
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (point_values_due.size() != 0)
            report_mismatch("point value never delivered", '0, point_values_due.pop_front());
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
